>>> hdl/allocation_trace_record_filter_core_defines.svh
// assertion macros shared by the checker
`ifndef ALLOCATION_TRACE_RECORD_FILTER_CORE_DEFINES_SVH
`define ALLOCATION_TRACE_RECORD_FILTER_CORE_DEFINES_SVH

// same-cycle implication, idle while reset is low
`define ATRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle while reset is low
`define ATRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// checks the cycle after each clock edge with reset low
`define ATRF_ASSERT_RST(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/atrf_pkg.sv
`timescale 1ns / 1ps

package atrf_pkg;

  localparam int FILTER_SETS_DEF = 16;

  localparam int SERIAL_W   = 32;
  localparam int SYNC_W     = 8;
  localparam int SPACE_W    = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [SYNC_W-1:0]  SYNC_PERIOD_RST = 8'd128;
  localparam logic [SPACE_W-1:0] BUFFER_CAP_RST  = 20'd1000000;
  localparam logic [31:0]        CLASS_FILL      = 32'd1;

  // set index residue datapath
  localparam int FOLD_W      = 18;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 27;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAP  = 1'b1;

  // record slots in emit order
  localparam int SLOT_SYNC  = 0;
  localparam int SLOT_MAIN  = 1;
  localparam int SLOT_CLASS = 2;
  localparam int SLOT_FLUSH = 3;
  localparam int NUM_SLOTS  = 4;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_EXEC  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ALLOC = 3'd0,
    KIND_FREE  = 3'd1,
    KIND_SYNC  = 3'd2,
    KIND_CLASS = 3'd3,
    KIND_EXEC  = 3'd4,
    KIND_FLUSH = 3'd5
  } kind_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] obj_class;
    logic [31:0] obj_size;
    logic [31:0] freed_id;
    logic [31:0] code_addr;
    logic [63:0] wall_time;
  } item_t;

  typedef struct packed {
    kind_t               main_kind;
    logic [SERIAL_W-1:0] serial_pre;
    logic [SERIAL_W-1:0] serial_post;
    logic [31:0]         obj_size;
    logic [31:0]         obj_class;
    logic [31:0]         freed_id;
    logic [31:0]         code_addr;
    logic [63:0]         wall_time;
  } rec_bundle_t;

  typedef struct packed {
    logic                 load;
    logic [NUM_SLOTS-1:0] pend;
    rec_bundle_t          rec;
  } rec_load_t;

endpackage

>>> hdl/atrf_ram.sv
`timescale 1ns / 1ps

module atrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/atrf_set_index.sv
`timescale 1ns / 1ps

module atrf_set_index #(
  parameter int FILTER_SETS = atrf_pkg::FILTER_SETS_DEF,
  parameter int SET_W       = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  atrf_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output atrf_pkg::item_t   out_item,
  output logic [SET_W-1:0]  out_set
);

  localparam int FW = atrf_pkg::FOLD_W;
  localparam int RW = atrf_pkg::RECIP_W;
  localparam int PW = FW + RW;

  // weights of the class bytes modulo the set count
  localparam logic [7:0] W1 = 8'(256 % FILTER_SETS);
  localparam logic [7:0] W2 = 8'(65536 % FILTER_SETS);
  localparam logic [7:0] W3 = 8'(16777216 % FILTER_SETS);
  localparam logic [RW-1:0] RECIP =
    RW'(((2 ** atrf_pkg::RECIP_SHIFT) + FILTER_SETS - 1) / FILTER_SETS);
  localparam logic [8:0] SETS_C = 9'(FILTER_SETS);

  logic            st1_v_r, st1_v_nxt;
  atrf_pkg::item_t st1_item_r;
  logic [FW-1:0]   st1_fold_r;
  logic            st2_v_r, st2_v_nxt;
  atrf_pkg::item_t st2_item_r;
  logic [FW-1:0]   st2_fold_r;
  logic [FW-1:0]   st2_quot_r;

  logic          st1_ready, st2_ready, in_fire;
  logic [29:0]   cls_sh;
  logic [FW-1:0] fold_sum;
  logic [PW-1:0] recip_prod;
  logic [26:0]   back_prod;
  logic [FW-1:0] residue;

  assign st2_ready = !st2_v_r || out_ready;
  assign st1_ready = !st1_v_r || st2_ready;
  assign in_ready  = st1_ready;
  assign in_fire   = in_valid && st1_ready;

  // fold the class, shifted right by two, into a short value with the same residue
  assign cls_sh   = in_item.obj_class[31:2];
  assign fold_sum = FW'(cls_sh[7:0])
                  + FW'(cls_sh[15:8]) * FW'(W1)
                  + FW'(cls_sh[23:16]) * FW'(W2)
                  + FW'(cls_sh[29:24]) * FW'(W3);

  assign recip_prod = PW'(st1_fold_r) * PW'(RECIP);

  assign back_prod = 27'(st2_quot_r) * 27'(SETS_C);
  assign residue   = st2_fold_r - back_prod[FW-1:0];

  assign st1_v_nxt = (st1_v_r && !st2_ready) || in_fire;
  assign st2_v_nxt = (st2_v_r && !out_ready) || (st1_v_r && st2_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
    end else begin
      st1_v_r <= st1_v_nxt;
      st2_v_r <= st2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st1_item_r <= in_item;
      st1_fold_r <= fold_sum;
    end
    if (st1_v_r && st2_ready) begin
      st2_item_r <= st1_item_r;
      st2_fold_r <= st1_fold_r;
      st2_quot_r <= recip_prod[PW-1:atrf_pkg::RECIP_SHIFT];
    end
  end

  assign out_valid = st2_v_r;
  assign out_item  = st2_item_r;
  assign out_set   = residue[SET_W-1:0];

endmodule

>>> hdl/atrf_engine.sv
`timescale 1ns / 1ps

module atrf_engine #(
  parameter int FILTER_SETS = atrf_pkg::FILTER_SETS_DEF,
  parameter int SET_W       = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [atrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [atrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  atrf_pkg::item_t                   in_item,
  input  logic [SET_W-1:0]                  in_set,
  input  logic                              seq_ready,
  output atrf_pkg::rec_load_t               rec_load
);

  localparam int ROW_W = 64;

  logic [atrf_pkg::SYNC_W-1:0]   sync_period_r;
  logic [atrf_pkg::SPACE_W-1:0]  buffer_cap_r;
  logic [atrf_pkg::SERIAL_W-1:0] serial_r, serial_nxt;
  logic [atrf_pkg::SYNC_W-1:0]   countdown_r, countdown_nxt;
  logic [atrf_pkg::SPACE_W-1:0]  space_r, space_nxt;
  logic [FILTER_SETS-1:0]        row_valid_r, row_valid_nxt;

  logic            st3_v_r, st3_v_nxt;
  atrf_pkg::item_t st3_item_r;
  logic [SET_W-1:0] st3_set_r;

  logic             fwd_v_r;
  logic [SET_W-1:0] fwd_set_r;
  logic [ROW_W-1:0] fwd_row_r;

  logic             st3_go, rd_en, wr_en;
  logic             is_alloc, is_free, is_exec, is_tick;
  logic [ROW_W-1:0] ram_rdata, row_cur, wr_row;
  logic [31:0]      way0, way1, cls;
  logic             class_miss, sync_due, flush;
  logic [atrf_pkg::SPACE_W-1:0] space_dec;

  assign is_alloc = st3_item_r.action == atrf_pkg::ACT_ALLOC;
  assign is_free  = st3_item_r.action == atrf_pkg::ACT_FREE;
  assign is_exec  = st3_item_r.action == atrf_pkg::ACT_EXEC;
  assign is_tick  = st3_item_r.action == atrf_pkg::ACT_TICK;

  // ticks make no records and never wait on the sequencer
  assign st3_go   = st3_v_r && (is_tick || seq_ready);
  assign in_ready = !st3_v_r || st3_go;
  assign rd_en    = in_valid && in_ready;

  atrf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (FILTER_SETS)
  ) u_filter_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (st3_set_r),
    .wdata (wr_row),
    .re    (rd_en),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  // a write in the same cycle as the read is not seen by the ram output
  always_comb begin
    if (fwd_v_r && (fwd_set_r == st3_set_r)) begin
      row_cur = fwd_row_r;
    end else if (row_valid_r[st3_set_r]) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = {atrf_pkg::CLASS_FILL, atrf_pkg::CLASS_FILL};
    end
  end

  assign cls  = st3_item_r.obj_class;
  assign way0 = row_cur[31:0];
  assign way1 = row_cur[63:32];

  assign class_miss = is_alloc && !((way0 == cls) || (way1 == cls));
  assign sync_due   = is_alloc && (countdown_r == '0);
  assign space_dec  = space_r - 1'b1;
  assign flush      = !is_tick && (space_dec == '0);

  assign wr_en  = st3_go && class_miss && !flush;
  assign wr_row = {way0, cls};

  always_comb begin
    serial_nxt    = serial_r;
    countdown_nxt = countdown_r;
    space_nxt     = space_r;
    row_valid_nxt = row_valid_r;
    if (st3_go) begin
      if (is_tick) begin
        countdown_nxt = '0;
      end else begin
        if (is_alloc) begin
          serial_nxt    = serial_r + 1'b1;
          countdown_nxt = sync_due ? sync_period_r : countdown_r - 1'b1;
        end
        if (flush) begin
          space_nxt     = buffer_cap_r;
          countdown_nxt = '0;
          row_valid_nxt = '0;
        end else begin
          space_nxt = space_dec;
          if (class_miss) begin
            row_valid_nxt[st3_set_r] = 1'b1;
          end
        end
      end
    end
  end

  assign st3_v_nxt = (st3_v_r && !st3_go) || rd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_period_r <= atrf_pkg::SYNC_PERIOD_RST;
      buffer_cap_r  <= atrf_pkg::BUFFER_CAP_RST;
      serial_r      <= '0;
      countdown_r   <= '0;
      space_r       <= atrf_pkg::BUFFER_CAP_RST;
      row_valid_r   <= '0;
      st3_v_r       <= 1'b0;
      fwd_v_r       <= 1'b0;
    end else begin
      serial_r    <= serial_nxt;
      countdown_r <= countdown_nxt;
      space_r     <= space_nxt;
      row_valid_r <= row_valid_nxt;
      st3_v_r     <= st3_v_nxt;
      if (rd_en) begin
        fwd_v_r <= wr_en;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          atrf_pkg::REG_SYNC_PERIOD: sync_period_r <= cfg_wdata[atrf_pkg::SYNC_W-1:0];
          atrf_pkg::REG_BUFFER_CAP:  buffer_cap_r  <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      st3_item_r <= in_item;
      st3_set_r  <= in_set;
      fwd_set_r  <= st3_set_r;
      fwd_row_r  <= wr_row;
    end
  end

  always_comb begin
    rec_load.load                       = st3_go && !is_tick;
    rec_load.pend                       = '0;
    rec_load.pend[atrf_pkg::SLOT_SYNC]  = sync_due;
    rec_load.pend[atrf_pkg::SLOT_MAIN]  = 1'b1;
    rec_load.pend[atrf_pkg::SLOT_CLASS] = class_miss;
    rec_load.pend[atrf_pkg::SLOT_FLUSH] = flush;
    if (is_free) begin
      rec_load.rec.main_kind = atrf_pkg::KIND_FREE;
    end else if (is_exec) begin
      rec_load.rec.main_kind = atrf_pkg::KIND_EXEC;
    end else begin
      rec_load.rec.main_kind = atrf_pkg::KIND_ALLOC;
    end
    rec_load.rec.serial_pre  = serial_r;
    rec_load.rec.serial_post = serial_nxt;
    rec_load.rec.obj_size    = st3_item_r.obj_size;
    rec_load.rec.obj_class   = cls;
    rec_load.rec.freed_id    = st3_item_r.freed_id;
    rec_load.rec.code_addr   = st3_item_r.code_addr;
    rec_load.rec.wall_time   = st3_item_r.wall_time;
  end

endmodule

>>> hdl/atrf_rec_seq.sv
`timescale 1ns / 1ps

module atrf_rec_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  atrf_pkg::rec_load_t           rec_load,
  output logic                          seq_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_record_kind,
  output logic [atrf_pkg::SERIAL_W-1:0] out_event_count,
  output logic [31:0]                   out_rec_size,
  output logic [31:0]                   out_rec_class,
  output logic [31:0]                   out_rec_id,
  output logic [31:0]                   out_rec_addr,
  output logic [63:0]                   out_rec_time,
  output logic                          out_last_record
);

  localparam int NS = atrf_pkg::NUM_SLOTS;

  logic [NS-1:0]         pend_r, pend_nxt;
  atrf_pkg::rec_bundle_t rec_r;

  logic [NS-1:0] cur, pend_left;
  logic          fire, last;
  logic          is_main_alloc;
  atrf_pkg::kind_t kind;

  // lowest pending slot goes out first
  always_comb begin
    cur = '0;
    priority if (pend_r[atrf_pkg::SLOT_SYNC]) begin
      cur[atrf_pkg::SLOT_SYNC] = 1'b1;
    end else if (pend_r[atrf_pkg::SLOT_MAIN]) begin
      cur[atrf_pkg::SLOT_MAIN] = 1'b1;
    end else if (pend_r[atrf_pkg::SLOT_CLASS]) begin
      cur[atrf_pkg::SLOT_CLASS] = 1'b1;
    end else if (pend_r[atrf_pkg::SLOT_FLUSH]) begin
      cur[atrf_pkg::SLOT_FLUSH] = 1'b1;
    end else begin
      cur = '0;
    end
  end

  assign pend_left = pend_r & ~cur;
  assign last      = pend_left == '0;
  assign out_valid = pend_r != '0;
  assign fire      = out_valid && out_ready;
  assign seq_ready = !out_valid || (fire && last);

  always_comb begin
    pend_nxt = pend_r;
    if (rec_load.load) begin
      pend_nxt = rec_load.pend;
    end else if (fire) begin
      pend_nxt = pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load.load) begin
      rec_r <= rec_load.rec;
    end
  end

  always_comb begin
    if (cur[atrf_pkg::SLOT_SYNC]) begin
      kind = atrf_pkg::KIND_SYNC;
    end else if (cur[atrf_pkg::SLOT_CLASS]) begin
      kind = atrf_pkg::KIND_CLASS;
    end else if (cur[atrf_pkg::SLOT_FLUSH]) begin
      kind = atrf_pkg::KIND_FLUSH;
    end else begin
      kind = rec_r.main_kind;
    end
  end

  assign is_main_alloc = cur[atrf_pkg::SLOT_MAIN] && (rec_r.main_kind == atrf_pkg::KIND_ALLOC);

  // a flush after an alloc carries the bumped serial
  assign out_record_kind = kind;
  assign out_event_count = cur[atrf_pkg::SLOT_FLUSH] ? rec_r.serial_post : rec_r.serial_pre;
  assign out_rec_size    = is_main_alloc ? rec_r.obj_size : '0;
  assign out_rec_class   = (is_main_alloc || cur[atrf_pkg::SLOT_CLASS]) ? rec_r.obj_class : '0;
  assign out_rec_id      = (cur[atrf_pkg::SLOT_MAIN] && (rec_r.main_kind == atrf_pkg::KIND_FREE))
                         ? rec_r.freed_id : '0;
  assign out_rec_addr    = (cur[atrf_pkg::SLOT_MAIN] && (rec_r.main_kind == atrf_pkg::KIND_EXEC))
                         ? rec_r.code_addr : '0;
  assign out_rec_time    = cur[atrf_pkg::SLOT_SYNC] ? rec_r.wall_time : '0;
  assign out_last_record = last;

endmodule

>>> hdl/allocation_trace_record_filter_core.sv
`timescale 1ns / 1ps

// Allocation trace record filter. Each accepted item passes a two-stage front end
// (input register with the class byte fold, then a reciprocal multiply for the filter
// set index). A filter stage then reads the class cache RAM, updates the serial, the
// sync countdown and the buffer space, and hands the item's records to a record register.
// The record register sends one record per cycle while out_ready is high, so the block
// takes one item per cycle while items make one record each and the output does not
// stall; an item that makes more than one record (up to four: time sync, main record,
// new class, flush) holds the record register until its last record is taken, and a
// timer tick passes the filter stage without waiting for the record register and makes
// no record. The class cache rows are marked valid in flip-flops, so reset and flush
// take effect at once with no clearing pass.
module allocation_trace_record_filter_core #(
  parameter int FILTER_SETS = atrf_pkg::FILTER_SETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic [31:0]                       in_obj_class,
  input  logic [31:0]                       in_obj_size,
  input  logic [31:0]                       in_freed_id,
  input  logic [31:0]                       in_code_addr,
  input  logic [63:0]                       in_wall_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_record_kind,
  output logic [31:0]                       out_event_count,
  output logic [31:0]                       out_rec_size,
  output logic [31:0]                       out_rec_class,
  output logic [31:0]                       out_rec_id,
  output logic [31:0]                       out_rec_addr,
  output logic [63:0]                       out_rec_time,
  output logic                              out_last_record,
  input  logic                              cfg_we,
  input  logic [atrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [atrf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SET_W = (FILTER_SETS > 1) ? $clog2(FILTER_SETS) : 1;

  atrf_pkg::item_t     in_item, idx_item;
  logic                idx_valid, idx_ready, seq_ready;
  logic [SET_W-1:0]    idx_set;
  atrf_pkg::rec_load_t rec_load;

  always_comb begin
    in_item.action    = atrf_pkg::action_t'(in_action);
    in_item.obj_class = in_obj_class;
    in_item.obj_size  = in_obj_size;
    in_item.freed_id  = in_freed_id;
    in_item.code_addr = in_code_addr;
    in_item.wall_time = in_wall_time;
  end

  atrf_set_index #(
    .FILTER_SETS (FILTER_SETS),
    .SET_W       (SET_W)
  ) u_set_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (idx_valid),
    .out_ready (idx_ready),
    .out_item  (idx_item),
    .out_set   (idx_set)
  );

  atrf_engine #(
    .FILTER_SETS (FILTER_SETS),
    .SET_W       (SET_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (idx_valid),
    .in_ready  (idx_ready),
    .in_item   (idx_item),
    .in_set    (idx_set),
    .seq_ready (seq_ready),
    .rec_load  (rec_load)
  );

  atrf_rec_seq u_rec_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_load        (rec_load),
    .seq_ready       (seq_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_record_kind (out_record_kind),
    .out_event_count (out_event_count),
    .out_rec_size    (out_rec_size),
    .out_rec_class   (out_rec_class),
    .out_rec_id      (out_rec_id),
    .out_rec_addr    (out_rec_addr),
    .out_rec_time    (out_rec_time),
    .out_last_record (out_last_record)
  );

endmodule

>>> hdl/atrf_checker.sv
`timescale 1ns / 1ps
`include "allocation_trace_record_filter_core_defines.svh"

module atrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_record_kind,
  input logic [31:0] out_event_count,
  input logic [63:0] out_rec_time,
  input logic        out_last_record
);

  // a waiting record keeps its kind, serial and end mark
  `ATRF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_record_kind) && $stable(out_event_count) && $stable(out_last_record), "record changed while stalled")

  // a time sync record is never the last record of its item
  `ATRF_ASSERT_IMP(a_sync_not_last, clk, rst_n, out_valid && (out_record_kind == atrf_pkg::KIND_SYNC), !out_last_record, "time sync record marked last")

  // a flush marker always ends its item and carries no time stamp
  `ATRF_ASSERT_IMP(a_flush_last, clk, rst_n, out_valid && (out_record_kind == atrf_pkg::KIND_FLUSH), out_last_record && (out_rec_time == '0), "flush marker not last")

  `ATRF_ASSERT_RST(a_reset_idle, clk, rst_n, !out_valid, "record pending after reset")

endmodule

bind allocation_trace_record_filter_core atrf_checker u_atrf_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import atrf_pkg::*;

  localparam int SETS           = FILTER_SETS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 16;
  localparam int PRINT_CAP      = 25;

  typedef struct {
    kind_t       kind;
    logic [31:0] count;
    logic [31:0] size;
    logic [31:0] cls;
    logic [31:0] id;
    logic [31:0] addr;
    logic [63:0] stamp;
    logic        last;
  } trace_rec_t;

  typedef struct {
    item_t ev;
    bit    typed;
    int    t_n;
    kind_t t_k0;
    kind_t t_k1;
  } row_t;

  typedef struct {
    logic [7:0]  sync;
    logic [19:0] cap;
    int          items;
    int          in_pct;
    int          out_pct;
    bit          squeeze;
  } phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [31:0] in_obj_class;
  logic [31:0] in_obj_size;
  logic [31:0] in_freed_id;
  logic [31:0] in_code_addr;
  logic [63:0] in_wall_time;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_record_kind;
  logic [31:0] out_event_count;
  logic [31:0] out_rec_size;
  logic [31:0] out_rec_class;
  logic [31:0] out_rec_id;
  logic [31:0] out_rec_addr;
  logic [63:0] out_rec_time;
  logic        out_last_record;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  allocation_trace_record_filter_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_obj_class    (in_obj_class),
    .in_obj_size     (in_obj_size),
    .in_freed_id     (in_freed_id),
    .in_code_addr    (in_code_addr),
    .in_wall_time    (in_wall_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_record_kind (out_record_kind),
    .out_event_count (out_event_count),
    .out_rec_size    (out_rec_size),
    .out_rec_class   (out_rec_class),
    .out_rec_id      (out_rec_id),
    .out_rec_addr    (out_rec_addr),
    .out_rec_time    (out_rec_time),
    .out_last_record (out_last_record),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // trace state mirror
  logic [31:0] serial_cnt;
  logic [7:0]  sync_left;
  logic [7:0]  sync_reload;
  logic [19:0] space_cnt;
  logic [19:0] flush_reload;
  logic [31:0] class_cache [2*SETS];

  trace_rec_t  fresh[$];
  trace_rec_t  records_due[$];
  logic [31:0] class_pool [8];

  int errors          = 0;
  int items_sent      = 0;
  int records_checked = 0;
  int flushes_seen    = 0;
  int syncs_seen      = 0;
  int classes_seen    = 0;
  int in_idle_pct     = 0;
  int out_idle_pct    = 0;
  int hold_left       = 0;
  int unsigned quiet_cycles = 0;

  function automatic void refill_cache();
    for (int i = 0; i < 2*SETS; i++) class_cache[i] = CLASS_FILL;
  endfunction

  function automatic void add_rec(kind_t k, logic [31:0] sz, logic [31:0] cl,
                                  logic [31:0] id, logic [31:0] ad, logic [63:0] ts);
    trace_rec_t r;
    r.kind  = k;
    r.count = serial_cnt;
    r.size  = sz;
    r.cls   = cl;
    r.id    = id;
    r.addr  = ad;
    r.stamp = ts;
    r.last  = 1'b0;
    fresh.push_back(r);
  endfunction

  function automatic void consume_space();
    space_cnt = space_cnt - 20'd1;
    if (space_cnt == '0) begin
      add_rec(KIND_FLUSH, '0, '0, '0, '0, '0);
      space_cnt = flush_reload;
      sync_left = '0;
      refill_cache();
    end
  endfunction

  // records an accepted item produces, in emit order
  function automatic void derive_records(input item_t ev);
    int unsigned set_idx;
    fresh.delete();
    case (ev.action)
      ACT_ALLOC: begin
        set_idx = (ev.obj_class >> 2) % SETS;
        if (sync_left != '0) begin
          sync_left = sync_left - 8'd1;
        end else begin
          add_rec(KIND_SYNC, '0, '0, '0, '0, ev.wall_time);
          sync_left = sync_reload;
        end
        add_rec(KIND_ALLOC, ev.obj_size, ev.obj_class, '0, '0, '0);
        if (class_cache[2*set_idx] != ev.obj_class &&
            class_cache[2*set_idx+1] != ev.obj_class) begin
          class_cache[2*set_idx+1] = class_cache[2*set_idx];
          class_cache[2*set_idx]   = ev.obj_class;
          add_rec(KIND_CLASS, '0, ev.obj_class, '0, '0, '0);
        end
        serial_cnt = serial_cnt + 32'd1;
        consume_space();
      end
      ACT_FREE: begin
        add_rec(KIND_FREE, '0, '0, ev.freed_id, '0, '0);
        consume_space();
      end
      ACT_EXEC: begin
        add_rec(KIND_EXEC, '0, '0, '0, ev.code_addr, '0);
        consume_space();
      end
      default: sync_left = '0;
    endcase
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) records_due.push_back(fresh[i]);
  endfunction

  function automatic logic [31:0] wide_word();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
    return $urandom;
  endfunction

  function automatic item_t random_event();
    item_t       ev;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45)      ev.action = ACT_ALLOC;
    else if (pick < 65) ev.action = ACT_FREE;
    else if (pick < 85) ev.action = ACT_EXEC;
    else                ev.action = ACT_TICK;
    // mostly a small pool crowded into two sets, so ways get evicted and re-hit
    pick = $urandom_range(9);
    if (pick < 7)      ev.obj_class = class_pool[$urandom_range(7)];
    else if (pick < 9) ev.obj_class = $urandom;
    else               ev.obj_class = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
    ev.obj_size  = wide_word();
    ev.freed_id  = wide_word();
    ev.code_addr = wide_word();
    ev.wall_time = {wide_word(), wide_word()};
    return ev;
  endfunction

  // called just after a rising edge; returns at the edge that takes the item
  task automatic offer(input item_t ev);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_action    <= ev.action;
    in_obj_class <= ev.obj_class;
    in_obj_size  <= ev.obj_size;
    in_freed_id  <= ev.freed_id;
    in_code_addr <= ev.code_addr;
    in_wall_time <= ev.wall_time;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    derive_records(ev);
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sp, input logic [19:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_PERIOD;
    cfg_wdata <= {12'd0, sp};
    @(posedge clk);
    cfg_index <= REG_BUFFER_CAP;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync_reload  = sp;
    flush_reload = cap;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    trace_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (records_due.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: record kind %0d count %h arrived, expected none", $time,
                   out_record_kind, out_event_count);
      end else begin
        want = records_due.pop_front();
        check_field("record_kind", want.kind, out_record_kind);
        check_field("event_count", want.count, out_event_count);
        check_field("rec_size", want.size, out_rec_size);
        check_field("rec_class", want.cls, out_rec_class);
        check_field("rec_id", want.id, out_rec_id);
        check_field("rec_addr", want.addr, out_rec_addr);
        check_field("rec_time", want.stamp, out_rec_time);
        check_field("last_record", want.last, out_last_record);
        records_checked++;
        if (want.kind == KIND_FLUSH) flushes_seen++;
        if (want.kind == KIND_SYNC)  syncs_seen++;
        if (want.kind == KIND_CLASS) classes_seen++;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // first rows run from reset: countdown zero, period 128, cache filled with one
  row_t plan [19] = '{
    '{'{ACT_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_FREE,  32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 64'd0},
        1'b1, 1, KIND_FREE, KIND_ALLOC},
    '{'{ACT_EXEC,  32'd0, 32'd0, 32'd0, 32'd0, 64'd0},
        1'b1, 1, KIND_EXEC, KIND_ALLOC},
    '{'{ACT_EXEC,  32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 64'd0},
        1'b1, 1, KIND_EXEC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF},
        1'b1, 2, KIND_SYNC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0},
        1'b1, 2, KIND_ALLOC, KIND_CLASS},
    '{'{ACT_ALLOC, 32'd0, 32'd5, 32'd0, 32'd0, 64'd0},
        1'b1, 1, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'h40, 32'd7, 32'd0, 32'd0, 64'd0}, 1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'd0, 32'd9, 32'd0, 32'd0, 64'd0}, 1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'h80, 32'd1, 32'd0, 32'd0, 64'd0}, 1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'd0, 32'd2, 32'd0, 32'd0, 64'd0}, 1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 64'd0},
        1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'hFFFF_FFFC, 32'd3, 32'd0, 32'd0, 64'd0},
        1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_TICK,  32'd0, 32'd0, 32'd0, 32'd0, 64'd0}, 1'b1, 0, KIND_ALLOC, KIND_ALLOC},
    // tick forced a sync; class sits in way1 of set 15
    '{'{ACT_ALLOC, 32'hFFFF_FFFF, 32'd4, 32'd0, 32'd0, 64'd0},
        1'b1, 2, KIND_SYNC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'd3, 32'd6, 32'd0, 32'd0, 64'h8000_0000_0000_0001},
        1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_FREE,  32'd0, 32'd0, 32'd0, 32'd0, 64'd0}, 1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_EXEC,  32'd0, 32'd0, 32'd0, 32'h8000_0001, 64'd0},
        1'b0, 0, KIND_ALLOC, KIND_ALLOC},
    '{'{ACT_ALLOC, 32'd4, 32'd8, 32'd0, 32'd0, 64'd0}, 1'b0, 0, KIND_ALLOC, KIND_ALLOC}
  };

  // capacity writes land at the next flush; zero capacity makes space wrap afterwards
  phase_t phases [5] = '{
    '{8'd0,   20'd1,      30, 28, 63, 1'b0},
    '{8'd255, 20'd5,      50, 28, 63, 1'b0},
    '{8'd2,   20'd17,     60, 63, 28, 1'b0},
    '{8'd1,   20'd0,      50, 63, 28, 1'b0},
    '{8'd128, 20'hFFFFF,  50, 0,  0,  1'b1}
  };

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_TICK;
    in_obj_class <= '0;
    in_obj_size  <= '0;
    in_freed_id  <= '0;
    in_code_addr <= '0;
    in_wall_time <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_SYNC_PERIOD;
    cfg_wdata    <= '0;
    out_ready    <= 1'b0;
    serial_cnt   = '0;
    sync_left    = '0;
    sync_reload  = SYNC_PERIOD_RST;
    space_cnt    = BUFFER_CAP_RST;
    flush_reload = BUFFER_CAP_RST;
    refill_cache();
    foreach (class_pool[i])
      class_pool[i] = ($urandom & ~32'h3C) | (32'($urandom_range(1)) << 2);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 28;
    out_idle_pct = 63;
    foreach (plan[i]) begin
      offer(plan[i].ev);
      if (plan[i].typed && (fresh.size() != plan[i].t_n ||
          (plan[i].t_n > 0 && fresh[0].kind != plan[i].t_k0) ||
          (plan[i].t_n > 1 && fresh[1].kind != plan[i].t_k1))) begin
        errors++;
        $display("%0t: row %0d expected %0d records (%0d, %0d), actual %0d", $time, i,
                 plan[i].t_n, plan[i].t_k0, plan[i].t_k1, fresh.size());
      end
    end

    foreach (phases[p]) begin
      drain(SETTLE_CYCLES);
      set_config(phases[p].sync, phases[p].cap);
      in_idle_pct  = phases[p].in_pct;
      out_idle_pct = phases[p].out_pct;
      if (phases[p].squeeze) hold_left = HOLD_CYCLES;
      repeat (phases[p].items) offer(random_event());
    end

    drain(TAIL_CYCLES);
    $display("%0d items, %0d records checked", items_sent, records_checked);
    $display("%0d flush, %0d time sync, %0d new class records; %0d errors", flushes_seen,
             syncs_seen, classes_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
